// ----- hdl/aewb_pkg.sv -----
package aewb_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W = 64;
  localparam int unsigned DIV_D_W = 56;
  localparam int unsigned DIV_C_W = $clog2(DIV_N_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METERING = 3'd0,
    CFG_TARGET   = 3'd1,
    CFG_EXP_RATE = 3'd2,
    CFG_SH_MAX   = 3'd3,
    CFG_GAIN_MAX = 3'd4,
    CFG_WB_RATE  = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] MODE_SPOT   = 2'd0;
  localparam logic [1:0] MODE_CENTER = 2'd1;

  localparam logic [1:0]  MODE_RESET     = 2'd2;
  localparam logic [10:0] TARGET_RESET   = 11'd184;
  localparam logic [10:0] EXP_RATE_RESET = 11'd512;
  localparam logic [13:0] SH_MAX_RESET   = 14'd1600;
  localparam logic [7:0]  GAIN_MAX_RESET = 8'd60;
  localparam logic [10:0] WB_RATE_RESET  = 11'd512;

  localparam logic [23:0] SH_RESET    = 24'd512000;
  localparam logic [17:0] GAIN_RESET  = 18'd1024;
  localparam logic [19:0] RED_RESET   = 20'd1946;
  localparam logic [19:0] GREEN_RESET = 20'd1024;
  localparam logic [19:0] BLUE_RESET  = 20'd2252;

  localparam logic [23:0] ONE_Q10      = 24'd1024;
  localparam logic [23:0] SAT24        = 24'hFFFFFF;
  localparam logic [23:0] SH_FLOOR     = 24'd4096;
  localparam logic [19:0] WB_CLAMP     = 20'd1047552;
  localparam logic [19:0] WB_MAX       = 20'hFFFFF;
  localparam logic [21:0] BRIGHT_K     = 22'd4166400;
  localparam logic [9:0]  FRAME_K      = 10'd765;
  localparam logic [11:0] SPOT_K       = 12'd765;
  localparam logic [11:0] CENTER_K     = 12'd2295;
  localparam logic [13:0] LONG_SHUTTER = 14'd810;
  localparam logic [13:0] BASE_FRAME   = 14'd802;
  localparam logic [63:0] SCENE_LO     = 64'd51200;
  localparam logic [63:0] SCENE_SPAN   = 64'd153600;
  // 2^32 / 150 rounded up, exact for offsets up to SCENE_SPAN
  localparam logic [24:0] SCENE_RECIP  = 25'd28633116;
  localparam logic [10:0] WEIGHT_ONE   = 11'd1024;
  localparam logic [15:0] CODE_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [7:0] spot_red;
    logic [7:0] spot_green;
    logic [7:0] spot_blue;
    logic [7:0] frame_red;
    logic [7:0] frame_green;
    logic [7:0] frame_blue;
  } in_item_t;

  typedef struct packed {
    logic [13:0] shutter_lines;
    logic [13:0] frame_length;
    logic [7:0]  analog_gain_code;
    logic [15:0] red_gain_code;
    logic [15:0] green_gain_code;
    logic [15:0] blue_gain_code;
  } out_item_t;

  function automatic logic [13:0] round_shutter(logic [23:0] q);
    logic [13:0] whole;
    logic        inc;
    whole = q[23:10];
    inc   = (q[9:0] > 10'd512) || ((q[9:0] == 10'd512) && whole[0]);
    if (inc && (whole != 14'h3FFF)) begin
      return whole + 14'd1;
    end
    return whole;
  endfunction

  function automatic logic [7:0] round_gain(logic [17:0] q);
    logic [7:0] whole;
    logic       inc;
    whole = q[17:10];
    inc   = (q[9:0] > 10'd512) || ((q[9:0] == 10'd512) && whole[0]);
    if (inc && (whole != 8'hFF)) begin
      return whole + 8'd1;
    end
    return whole;
  endfunction

  function automatic logic [15:0] color_code(logic [19:0] g);
    return (g[19:2] > 18'(CODE_MAX)) ? CODE_MAX : g[17:2];
  endfunction

endpackage

// ----- hdl/aewb_stream_if.sv -----
interface aewb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/auto_exposure_white_balance_core.sv -----
// Channel  | Dir | Handshake    | Payload
// in_i     | in  | valid/ready  | aewb_pkg::in_item_t, one metering sample
// out_o    | out | valid/ready  | aewb_pkg::out_item_t, one result per sample
// cfg      | in  | cfg_we_i     | cfg_idx_i selects register, cfg_data_i value
//
// Each sample runs through the sequencing states and up to six passes through the
// shared 64-bit restoring divider (a zero divisor skips its pass); the core returns
// to idle, ready for the next sample, as the result is registered.
// All products go through one shared 34x24 multiplier, one per cycle.
// rst_ni clears state, gains and registers to their reset values at once.
// in_i.ready is high only while idle; the result register lets the next
// sample in while the last result waits on out_o.ready.
module auto_exposure_white_balance_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [aewb_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [aewb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  aewb_stream_if.sink                            in_i,
  aewb_stream_if.source                          out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_RATIO, S_RATIO_DIV, S_RATIO_END, S_ERR_MUL, S_ERR_END,
    S_EXP1, S_EXP2, S_EXP3, S_EXP4, S_EXP5, S_EXP6, S_EXP7,
    S_WB_X1, S_WB_X2, S_WB_X3, S_NG1, S_NG2, S_NG3, S_NG4,
    S_SC1, S_SC2, S_SC3, S_SC4, S_SC5, S_SC6,
    S_BL1, S_BL2, S_BL3, S_BL4, S_OUT, S_DIV
  } state_e;

  state_e state_q, ret_q;

  logic [1:0]  mode_q;
  logic [10:0] target_q, erate_q, brate_q;
  logic [13:0] smax_q;
  logic [7:0]  gmax_q;

  logic [23:0] sh_q;
  logic [17:0] g_q;
  logic [19:0] gain_q [3];
  logic [19:0] newg_q [3];
  logic [7:0]  m_q [3];
  logic [9:0]  ssum_q, msum_q;
  logic [23:0] ratio_q, err_q, old_q, e2_q;
  logic        neg_q, up_q, dneg_q;
  logic [1:0]  c_q, w_q;
  logic [63:0] t_q;
  logic [10:0] weight_q;
  logic [21:0] wr_q;
  logic [aewb_pkg::PROD_W-1:0]  prod_q;
  logic [aewb_pkg::DIV_N_W-1:0] div_quo_q;
  logic [aewb_pkg::DIV_D_W-1:0] div_den_q, div_rem_q;
  logic [aewb_pkg::DIV_C_W-1:0] div_cnt_q;
  logic                         out_valid_q;
  aewb_pkg::out_item_t          out_q;

  logic [aewb_pkg::MUL_A_W-1:0] mul_a;
  logic [aewb_pkg::MUL_B_W-1:0] mul_b;
  logic [aewb_pkg::PROD_W-1:0]  mul_p;
  logic [11:0] bsum, kval;
  logic [9:0]  in_ssum, in_msum;
  logic        up_now;
  logic [23:0] sh_cap;
  logic [17:0] g_cap;
  logic [20:0] diff_abs;
  logic        diff_neg;
  logic [aewb_pkg::DIV_D_W:0]   rem_sh;
  logic                         rem_ge;
  logic [aewb_pkg::DIV_D_W-1:0] rem_nx;
  logic [47:0] prod_sh10;
  logic [23:0] err_val;
  logic signed [23:0] blend_v;
  logic [19:0] blend_g;
  logic [63:0] scene_off;
  logic [17:0] scene_clip;
  logic [13:0] sl;

  assign in_ssum = 10'(in_i.payload.spot_red) + 10'(in_i.payload.spot_green)
                 + 10'(in_i.payload.spot_blue);
  assign in_msum = 10'(in_i.payload.frame_red) + 10'(in_i.payload.frame_green)
                 + 10'(in_i.payload.frame_blue);

  always_comb begin
    unique case (mode_q)
      aewb_pkg::MODE_SPOT: begin
        bsum = 12'(ssum_q);
        kval = aewb_pkg::SPOT_K;
      end
      aewb_pkg::MODE_CENTER: begin
        bsum = {1'b0, ssum_q, 1'b0} + 12'(msum_q);
        kval = aewb_pkg::CENTER_K;
      end
      default: begin
        bsum = 12'(msum_q);
        kval = aewb_pkg::SPOT_K;
      end
    endcase
  end

  assign up_now    = err_q > aewb_pkg::ONE_Q10;
  assign sh_cap    = {((smax_q < 14'd4) ? 14'd4 : smax_q), 10'd0};
  assign g_cap     = {((gmax_q == 8'd0) ? 8'd1 : gmax_q), 10'd0};
  assign diff_neg  = newg_q[c_q] < gain_q[c_q];
  assign diff_abs  = diff_neg ? 21'(gain_q[c_q] - newg_q[c_q])
                              : 21'(newg_q[c_q] - gain_q[c_q]);
  assign prod_sh10 = prod_q[57:10];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_RATIO: begin
        mul_a = 34'(target_q);
        mul_b = 24'(kval);
      end
      S_ERR_MUL: begin
        mul_a = 34'(erate_q);
        mul_b = (ratio_q >= aewb_pkg::ONE_Q10) ? ratio_q - aewb_pkg::ONE_Q10
                                               : aewb_pkg::ONE_Q10 - ratio_q;
      end
      S_EXP1: begin
        mul_a = up_now ? 34'(sh_q) : 34'(g_q);
        mul_b = err_q;
      end
      S_EXP3: begin
        mul_a = 34'(err_q);
        mul_b = old_q;
      end
      S_EXP6: begin
        mul_a = up_q ? 34'(g_q) : 34'(sh_q);
        mul_b = e2_q;
      end
      S_WB_X1: begin
        mul_a = 34'(m_q[c_q]);
        mul_b = 24'(gain_q[w_q]);
      end
      S_WB_X2: begin
        mul_a = 34'(m_q[w_q]);
        mul_b = 24'(gain_q[c_q]);
      end
      S_NG1: begin
        mul_a = 34'(gain_q[c_q]);
        mul_b = 24'(m_q[w_q]);
      end
      S_NG2: begin
        mul_a = 34'(gain_q[w_q]);
        mul_b = 24'(m_q[c_q]);
      end
      S_SC1: begin
        mul_a = 34'(aewb_pkg::BRIGHT_K);
        mul_b = 24'(msum_q);
      end
      S_SC2: begin
        mul_a = 34'(aewb_pkg::FRAME_K);
        mul_b = sh_q;
      end
      S_SC3: begin
        mul_a = prod_q[33:0];
        mul_b = 24'(g_q);
      end
      S_SC5: begin
        mul_a = 34'(aewb_pkg::SCENE_RECIP);
        mul_b = 24'(scene_clip);
      end
      S_BL1: begin
        mul_a = 34'(weight_q);
        mul_b = 24'(brate_q);
      end
      S_BL3: begin
        mul_a = 34'(diff_abs);
        mul_b = 24'(wr_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = aewb_pkg::PROD_W'(mul_a) * aewb_pkg::PROD_W'(mul_b);

  assign rem_sh = {div_rem_q, div_quo_q[aewb_pkg::DIV_N_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den_q};
  assign rem_nx = rem_ge ? aewb_pkg::DIV_D_W'(rem_sh - {1'b0, div_den_q})
                         : rem_sh[aewb_pkg::DIV_D_W-1:0];

  always_comb begin
    err_val = '0;
    if (neg_q) begin
      if (prod_q < 58'd1048576) begin
        err_val = 24'((58'd1048576 - prod_q) >> 10);
      end
    end else begin
      err_val = (prod_q[57:10] + 48'd1024 > 48'(aewb_pkg::SAT24))
              ? aewb_pkg::SAT24 : 24'(prod_q[57:10] + 48'd1024);
    end
  end

  always_comb begin
    if (dneg_q) begin
      blend_v = signed'(24'(gain_q[c_q])) - signed'(24'(prod_q[41:20]));
    end else begin
      blend_v = signed'(24'(gain_q[c_q])) + signed'(24'(prod_q[41:20]));
    end
    if (blend_v < 0) begin
      blend_g = '0;
    end else if (blend_v > signed'(24'(aewb_pkg::WB_MAX))) begin
      blend_g = aewb_pkg::WB_MAX;
    end else begin
      blend_g = blend_v[19:0];
    end
  end

  assign scene_off  = div_quo_q - aewb_pkg::SCENE_LO;
  assign scene_clip = (scene_off > aewb_pkg::SCENE_SPAN) ? 18'(aewb_pkg::SCENE_SPAN)
                                                         : scene_off[17:0];
  assign sl         = aewb_pkg::round_shutter(sh_q);

  assign in_i.ready    = state_q == S_IDLE;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      mode_q      <= aewb_pkg::MODE_RESET;
      target_q    <= aewb_pkg::TARGET_RESET;
      erate_q     <= aewb_pkg::EXP_RATE_RESET;
      smax_q      <= aewb_pkg::SH_MAX_RESET;
      gmax_q      <= aewb_pkg::GAIN_MAX_RESET;
      brate_q     <= aewb_pkg::WB_RATE_RESET;
      sh_q        <= aewb_pkg::SH_RESET;
      g_q         <= aewb_pkg::GAIN_RESET;
      gain_q[0]   <= aewb_pkg::RED_RESET;
      gain_q[1]   <= aewb_pkg::GREEN_RESET;
      gain_q[2]   <= aewb_pkg::BLUE_RESET;
      c_q         <= '0;
      w_q         <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= mul_p;

      if (cfg_we_i) begin
        unique case (aewb_pkg::cfg_idx_e'(cfg_idx_i))
          aewb_pkg::CFG_METERING: mode_q   <= cfg_data_i[1:0];
          aewb_pkg::CFG_TARGET:   target_q <= cfg_data_i[10:0];
          aewb_pkg::CFG_EXP_RATE: erate_q  <= cfg_data_i[10:0];
          aewb_pkg::CFG_SH_MAX:   smax_q   <= cfg_data_i;
          aewb_pkg::CFG_GAIN_MAX: gmax_q   <= cfg_data_i[7:0];
          aewb_pkg::CFG_WB_RATE:  brate_q  <= cfg_data_i[10:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            m_q[0]  <= in_i.payload.frame_red;
            m_q[1]  <= in_i.payload.frame_green;
            m_q[2]  <= in_i.payload.frame_blue;
            ssum_q  <= in_ssum;
            msum_q  <= in_msum;
            state_q <= S_RATIO;
          end
        end
        S_RATIO: state_q <= S_RATIO_DIV;
        S_RATIO_DIV: begin
          if (bsum == '0) begin
            ratio_q <= aewb_pkg::SAT24;
            state_q <= S_ERR_MUL;
          end else begin
            div_quo_q <= 64'(prod_q);
            div_den_q <= 56'(bsum);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            ret_q     <= S_RATIO_END;
            state_q   <= S_DIV;
          end
        end
        S_RATIO_END: begin
          ratio_q <= (div_quo_q > 64'(aewb_pkg::SAT24)) ? aewb_pkg::SAT24
                                                        : div_quo_q[23:0];
          state_q <= S_ERR_MUL;
        end
        S_ERR_MUL: begin
          neg_q   <= ratio_q < aewb_pkg::ONE_Q10;
          state_q <= S_ERR_END;
        end
        S_ERR_END: begin
          err_q   <= err_val;
          state_q <= S_EXP1;
        end
        S_EXP1: begin
          up_q    <= up_now;
          old_q   <= up_now ? sh_q : 24'(g_q);
          state_q <= S_EXP2;
        end
        S_EXP2: begin
          if (up_q) begin
            sh_q <= (prod_sh10 > 48'(sh_cap)) ? sh_cap : prod_sh10[23:0];
          end else begin
            g_q <= (prod_sh10 < 48'(aewb_pkg::ONE_Q10)) ? 18'(aewb_pkg::ONE_Q10)
                                                      : prod_sh10[17:0];
          end
          state_q <= S_EXP3;
        end
        S_EXP3: state_q <= S_EXP4;
        S_EXP4: begin
          if ((up_q ? sh_q : 24'(g_q)) == '0) begin
            e2_q    <= aewb_pkg::SAT24;
            state_q <= S_EXP6;
          end else begin
            div_quo_q <= 64'(prod_q);
            div_den_q <= up_q ? 56'(sh_q) : 56'(g_q);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            ret_q     <= S_EXP5;
            state_q   <= S_DIV;
          end
        end
        S_EXP5: begin
          e2_q    <= (div_quo_q > 64'(aewb_pkg::SAT24)) ? aewb_pkg::SAT24
                                                        : div_quo_q[23:0];
          state_q <= S_EXP6;
        end
        S_EXP6: begin
          c_q <= 2'd1;
          w_q <= 2'd0;
          if ((up_q && (e2_q > aewb_pkg::ONE_Q10)) ||
              (!up_q && (e2_q < aewb_pkg::ONE_Q10))) begin
            state_q <= S_EXP7;
          end else begin
            state_q <= S_WB_X1;
          end
        end
        S_EXP7: begin
          if (up_q) begin
            g_q <= (prod_sh10 > 48'(g_cap)) ? g_cap : prod_sh10[17:0];
          end else begin
            sh_q <= (prod_sh10 < 48'(aewb_pkg::SH_FLOOR)) ? aewb_pkg::SH_FLOOR
                                                         : prod_sh10[23:0];
          end
          state_q <= S_WB_X1;
        end
        S_WB_X1: state_q <= S_WB_X2;
        S_WB_X2: begin
          t_q     <= 64'(prod_q);
          state_q <= S_WB_X3;
        end
        S_WB_X3: begin
          if (t_q > 64'(prod_q)) begin
            w_q <= c_q;
          end
          if (c_q == 2'd2) begin
            c_q     <= 2'd0;
            state_q <= S_NG1;
          end else begin
            c_q     <= c_q + 2'd1;
            state_q <= S_WB_X1;
          end
        end
        S_NG1: state_q <= S_NG2;
        S_NG2: begin
          t_q     <= 64'(prod_q) << 10;
          state_q <= S_NG3;
        end
        S_NG3: begin
          if (prod_q == '0) begin
            newg_q[c_q] <= aewb_pkg::WB_CLAMP;
            c_q         <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
            state_q     <= (c_q == 2'd2) ? S_SC1 : S_NG1;
          end else begin
            div_quo_q <= t_q;
            div_den_q <= 56'(prod_q);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            ret_q     <= S_NG4;
            state_q   <= S_DIV;
          end
        end
        S_NG4: begin
          newg_q[c_q] <= (div_quo_q > 64'(aewb_pkg::WB_CLAMP)) ? aewb_pkg::WB_CLAMP
                                                              : div_quo_q[19:0];
          c_q         <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
          state_q     <= (c_q == 2'd2) ? S_SC1 : S_NG1;
        end
        S_SC1: state_q <= S_SC2;
        S_SC2: begin
          t_q     <= 64'(prod_q) << 30;
          state_q <= S_SC3;
        end
        S_SC3: state_q <= S_SC4;
        S_SC4: begin
          if (prod_q == '0) begin
            weight_q <= aewb_pkg::WEIGHT_ONE;
            state_q  <= S_BL1;
          end else begin
            div_quo_q <= t_q;
            div_den_q <= 56'(prod_q);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            ret_q     <= S_SC5;
            state_q   <= S_DIV;
          end
        end
        S_SC5: begin
          if (div_quo_q <= aewb_pkg::SCENE_LO) begin
            weight_q <= '0;
            state_q  <= S_BL1;
          end else begin
            state_q  <= S_SC6;
          end
        end
        S_SC6: begin
          weight_q <= (prod_q[42:32] > aewb_pkg::WEIGHT_ONE) ? aewb_pkg::WEIGHT_ONE
                                                             : prod_q[42:32];
          state_q  <= S_BL1;
        end
        S_BL1: state_q <= S_BL2;
        S_BL2: begin
          wr_q    <= prod_q[21:0];
          c_q     <= 2'd0;
          state_q <= S_BL3;
        end
        S_BL3: begin
          dneg_q  <= diff_neg;
          state_q <= S_BL4;
        end
        S_BL4: begin
          gain_q[c_q] <= blend_g;
          if (c_q == 2'd2) begin
            c_q     <= 2'd0;
            state_q <= S_OUT;
          end else begin
            c_q     <= c_q + 2'd1;
            state_q <= S_BL3;
          end
        end
        S_OUT: begin
          if (!out_valid_q) begin
            out_q.shutter_lines    <= sl;
            out_q.frame_length     <= (sl > aewb_pkg::LONG_SHUTTER) ? sl
                                                                    : aewb_pkg::BASE_FRAME;
            out_q.analog_gain_code <= aewb_pkg::round_gain(g_q);
            out_q.red_gain_code    <= aewb_pkg::color_code(gain_q[0]);
            out_q.green_gain_code  <= aewb_pkg::color_code(gain_q[1]);
            out_q.blue_gain_code   <= aewb_pkg::color_code(gain_q[2]);
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        S_DIV: begin
          div_rem_q <= rem_nx;
          div_quo_q <= {div_quo_q[aewb_pkg::DIV_N_W-2:0], rem_ge};
          div_cnt_q <= div_cnt_q + aewb_pkg::DIV_C_W'(1);
          if (div_cnt_q == aewb_pkg::DIV_C_W'(aewb_pkg::DIV_N_W - 1)) begin
            state_q <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_sh_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_q >= aewb_pkg::SH_FLOOR) else $error("shutter below floor");

  a_gain_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_q >= 18'(aewb_pkg::ONE_Q10)) else $error("gain below unity");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_den_q != '0) else $error("divide by zero");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_RATIO) else $error("item not started");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.ready |=> !out_valid_q) else $error("result repeated");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import aewb_pkg::*;

  localparam logic [1:0] MODE_FRAME = 2'd2;
  localparam logic [1:0] MODE_ALIAS = 2'd3;
  localparam int GAP_MAX = 8;
  localparam int SETTLE_CYCLES = 700;
  localparam int HOLD_CYCLES = 3000;
  localparam int WATCHDOG_LIMIT = 40000;

  class aewb_scoreboard;
    logic [1:0]  mode;
    logic [10:0] target, exp_rate, wb_rate;
    logic [13:0] sh_max;
    logic [7:0]  g_max;
    longint unsigned shutter, gain;
    longint unsigned wb[3];
    out_item_t   expected_q[$];
    int          mismatches;

    function void reset_state();
      mode = MODE_FRAME; target = 184; exp_rate = 512;
      sh_max = 1600; g_max = 60; wb_rate = 512;
      shutter = 500 * 1024; gain = 1024;
      wb[0] = 1946; wb[1] = 1024; wb[2] = 2252;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_METERING: mode = v[1:0];
        CFG_TARGET:   target = v[10:0];
        CFG_EXP_RATE: exp_rate = v[10:0];
        CFG_SH_MAX:   sh_max = v[13:0];
        CFG_GAIN_MAX: g_max = v[7:0];
        CFG_WB_RATE:  wb_rate = v[10:0];
        default: ;
      endcase
    endfunction

    function longint unsigned div_sat(longint unsigned n, longint unsigned d,
                                      longint unsigned sat);
      longint unsigned q;
      if (d == 0) return sat;
      q = n / d;
      return (q > sat) ? sat : q;
    endfunction

    function longint unsigned round_half_even(longint unsigned q, longint unsigned cap);
      longint unsigned whole;
      longint unsigned frac;
      whole = q >> 10;
      frac = q & 1023;
      if (frac > 512 || (frac == 512 && whole[0])) whole++;
      return (whole > cap) ? cap : whole;
    endfunction

    function void note_input(in_item_t x);
      longint unsigned fr[3];
      longint unsigned spot_sum, frame_sum, bright, k, ratio, err, resid, cap, prev;
      longint unsigned lines, newg[3], num, den, scene, weight;
      longint          err_num, diff, v;
      int              w;
      out_item_t       r;
      fr[0] = x.frame_red; fr[1] = x.frame_green; fr[2] = x.frame_blue;
      spot_sum = x.spot_red + x.spot_green + x.spot_blue;
      frame_sum = fr[0] + fr[1] + fr[2];
      if (mode == MODE_SPOT) begin
        bright = spot_sum; k = 765;
      end else if (mode == MODE_CENTER) begin
        bright = 2 * spot_sum + frame_sum; k = 2295;
      end else begin
        bright = frame_sum; k = 765;
      end
      ratio = div_sat(target * k, bright, 64'hFFFFFF);
      err_num = 1048576 + longint'(exp_rate) * (longint'(ratio) - 1024);
      if (err_num <= 0) begin
        err = 0;
      end else begin
        err = longint'(err_num) >> 10;
        if (err > 64'hFFFFFF) err = 64'hFFFFFF;
      end
      if (err > 1024) begin
        prev = shutter;
        cap = ((sh_max < 4) ? 4 : sh_max) * 1024;
        shutter = (shutter * err) >> 10;
        if (shutter > cap) shutter = cap;
        resid = div_sat(err * prev, shutter, 64'hFFFFFF);
        if (resid > 1024) begin
          cap = ((g_max < 1) ? 1 : g_max) * 1024;
          gain = (gain * resid) >> 10;
          if (gain > cap) gain = cap;
        end
      end else begin
        prev = gain;
        gain = (gain * err) >> 10;
        if (gain < 1024) gain = 1024;
        resid = div_sat(err * prev, gain, 64'hFFFFFF);
        if (resid < 1024) begin
          shutter = (shutter * resid) >> 10;
          if (shutter < 4096) shutter = 4096;
        end
      end
      lines = round_half_even(shutter, 16383);
      r.shutter_lines = 14'(lines);
      r.frame_length = 14'((lines > 810) ? lines : 802);
      r.analog_gain_code = 8'(round_half_even(gain, 255));

      w = 0;
      for (int c = 1; c < 3; c++)
        if (fr[c] * wb[w] > fr[w] * wb[c]) w = c;
      for (int c = 0; c < 3; c++)
        newg[c] = div_sat(wb[c] * fr[w] * 1024, wb[w] * fr[c], 1023 * 1024);

      num = (64'd4166400 * frame_sum) << 30;
      den = 765 * shutter * gain;
      if (den == 0) begin
        weight = 1024;
      end else begin
        scene = num / den;
        weight = (scene <= 51200) ? 0 : (scene - 51200) / 150;
        if (weight > 1024) weight = 1024;
      end
      for (int c = 0; c < 3; c++) begin
        diff = longint'(newg[c]) - longint'(wb[c]);
        v = longint'(wb[c]) + (longint'(weight) * longint'(wb_rate) * diff) / 1048576;
        if (v < 0) v = 0;
        if (v > 1048575) v = 1048575;
        wb[c] = v;
      end
      r.red_gain_code = 16'(((wb[0] >> 2) > 65535) ? 65535 : (wb[0] >> 2));
      r.green_gain_code = 16'(((wb[1] >> 2) > 65535) ? 65535 : (wb[1] >> 2));
      r.blue_gain_code = 16'(((wb[2] >> 2) > 65535) ? 65535 : (wb[2] >> 2));
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.shutter_lines !== e.shutter_lines || got.frame_length !== e.frame_length ||
          got.analog_gain_code !== e.analog_gain_code ||
          got.red_gain_code !== e.red_gain_code ||
          got.green_gain_code !== e.green_gain_code ||
          got.blue_gain_code !== e.blue_gain_code) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  aewb_stream_if #(.payload_t(in_item_t))  sample_if ();
  aewb_stream_if #(.payload_t(out_item_t)) result_if ();

  auto_exposure_white_balance_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (sample_if.sink),
    .out_o      (result_if.source)
  );

  aewb_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int quiet_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL auto_exposure_white_balance_core");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Receiver: random stalls, one long hold-off when requested.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
      sb.check_result(result_if.payload);
    end
  end

  task automatic send_sample(in_item_t x);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.payload <= x;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    sb.note_input(x);
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] vals[6]);
    cfg_idx_e idx;
    for (int i = 0; i < 6; i++) begin
      idx = cfg_idx_e'(i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(idx, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t scene_sample();
    in_item_t x;
    int base;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      x = 48'({$urandom(), $urandom()});
    end else if (kind == 2) begin
      x = '0;
      if ($urandom_range(0, 1)) x.frame_green = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) x.spot_red = 8'($urandom_range(0, 255));
    end else begin
      base = $urandom_range(1, 255);
      x.spot_red = 8'($urandom_range(0, 255) % (base + 1));
      x.spot_green = 8'(base);
      x.spot_blue = 8'($urandom_range(0, 255) % (base + 1));
      base = $urandom_range(1, 255);
      x.frame_red = 8'(base - $urandom_range(0, base));
      x.frame_green = 8'(base);
      x.frame_blue = 8'(base - $urandom_range(0, base / 2));
    end
    return x;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] regs[6];
    in_item_t x;
    sb = new();
    sb.reset_state();
    no_idle = 0;
    hold_req = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    sample_if.valid = 1'b0;
    sample_if.payload = '0;
    result_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings
    send_sample('0);
    send_sample('1);
    send_sample({8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0});
    send_sample({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255});
    send_sample({8'd10, 8'd10, 8'd10, 8'd1, 8'd1, 8'd1});
    send_sample({8'd128, 8'd128, 8'd128, 8'd200, 8'd100, 8'd50});
    drain();

    regs = '{14'(MODE_SPOT), 14'd1024, 14'd1024, 14'd16383, 14'd248, 14'd1024};
    write_regs(regs);
    send_sample('0);
    send_sample({8'd1, 8'd0, 8'd0, 8'd40, 8'd40, 8'd40});
    for (int i = 0; i < 4; i++) send_sample({8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2});
    send_sample('1);
    drain();

    regs = '{14'(MODE_CENTER), 14'd0, 14'd0, 14'd0, 14'd0, 14'd0};
    write_regs(regs);
    send_sample('1);
    send_sample({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1});
    send_sample('0);
    drain();

    regs = '{14'(MODE_ALIAS), 14'd2047, 14'd2047, 14'd3, 14'd255, 14'd2047};
    write_regs(regs);
    send_sample({8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd1});
    send_sample({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
    send_sample('0);
    send_sample(48'({$urandom(), $urandom()}));
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: regs = '{14'(MODE_RESET), 14'(TARGET_RESET), 14'(EXP_RATE_RESET),
                    14'(SH_MAX_RESET), 14'(GAIN_MAX_RESET), 14'(WB_RATE_RESET)};
        1: regs = '{14'(MODE_SPOT), 14'd1024, 14'd1024, 14'd16383, 14'd248, 14'd1024};
        2: regs = '{14'(MODE_CENTER), 14'd0, 14'd0, 14'd4, 14'd1, 14'd0};
        default: regs = '{14'($urandom_range(0, 3)), 14'($urandom_range(0, 2047)),
                          14'($urandom_range(0, 2047)), 14'($urandom_range(0, 16383)),
                          14'($urandom_range(0, 255)), 14'($urandom_range(0, 2047))};
      endcase
      write_regs(regs);
      no_idle = (phase % 3 == 1);
      for (int i = 0; i < 150; i++) begin
        if (phase == 4 && i == 20) hold_req = 1;
        x = scene_sample();
        send_sample(x);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS auto_exposure_white_balance_core");
    end else begin
      $display("FAIL auto_exposure_white_balance_core");
    end
    $finish;
  end

endmodule
